// ===== sv/gasp_pkg.sv =====
`default_nettype none

package gasp_pkg;

   localparam int unsigned SHADOW_MARGIN = 0;
   localparam int unsigned MAX_PAGES     = 1024;
   localparam int unsigned FIT_SLACK     = 2;
   localparam int unsigned CURSOR_MAX    = 16383;
   localparam int unsigned USED_MAX      = 8192;
   localparam int unsigned PAGE_DIM_MAX  = 4096;
   localparam int unsigned RSP_DEPTH     = 4;

   typedef enum logic [1:0] {
      RK_PLACE = 2'd0,
      RK_CLOSE = 2'd1,
      RK_ERROR = 2'd2
   } rk_type;

   typedef enum logic {
      KIND_GLYPH  = 1'b0,
      KIND_FINISH = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      REG_PAGE_WIDTH  = 3'd0,
      REG_PAGE_HEIGHT = 3'd1,
      REG_PAD_X       = 3'd2,
      REG_PAD_Y       = 3'd3,
      REG_GROW_LEFT   = 3'd4,
      REG_GROW_RIGHT  = 3'd5,
      REG_GROW_TOP    = 3'd6,
      REG_GROW_BOTTOM = 3'd7
   } reg_type;

   typedef struct packed {
      logic        [12:0] page_width;
      logic        [12:0] page_height;
      logic        [7:0]  pad_x;
      logic        [7:0]  pad_y;
      logic signed [8:0]  grow_left;
      logic signed [8:0]  grow_right;
      logic signed [8:0]  grow_top;
      logic signed [8:0]  grow_bottom;
   } cfg_type;

   typedef struct packed {
      rk_type      result_kind;
      logic [11:0] start_u;
      logic [11:0] start_v;
      logic [12:0] size_u;
      logic [12:0] size_v;
      logic [9:0]  page_index;
      logic [13:0] used_height;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type item0;
      rsp_type item1;
   } push_type;

   // page size 0 acts as 1, above 4096 as 4096
   function automatic logic [12:0] eff_dim(input logic [12:0] v);
      logic [12:0] r;
      if (v == 13'd0) begin
         r = 13'd1;
      end else if (v > 13'(PAGE_DIM_MAX)) begin
         r = 13'(PAGE_DIM_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/glyph_atlas_shelf_packer.sv =====
// An accepted item goes into the input register; its results are written into the
// result queue, which drives rsp. Throughput: one item per cycle while the queue has
// room for two results; the packing state is updated once per item. An item that
// closes a page and places a glyph gives two results; the 4-entry queue sends them in turn.
// Reset (synchronous): cursors, row height, page index, queue cleared; registers to defaults.
`default_nettype none

module glyph_atlas_shelf_packer
   import gasp_pkg::*;
#(
   parameter int unsigned P_SHADOW_MARGIN = SHADOW_MARGIN,
   parameter int unsigned P_MAX_PAGES     = MAX_PAGES
)
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [11:0] req_glyph_width,
   input  wire logic [11:0] req_glyph_height,
   input  wire logic        req_from_outline,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [11:0]      rsp_start_u,
   output logic [11:0]      rsp_start_v,
   output logic [12:0]      rsp_size_u,
   output logic [12:0]      rsp_size_v,
   output logic [9:0]       rsp_page_index,
   output logic [13:0]      rsp_used_height,
   output logic             rsp_last,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type  cfg;
   push_type push;
   logic     room;
   rsp_type  rsp_item;

   gasp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gasp_core #(
      .P_SHADOW_MARGIN (P_SHADOW_MARGIN),
      .P_MAX_PAGES     (P_MAX_PAGES)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .req_from_outline (req_from_outline),
      .cfg              (cfg),
      .room             (room),
      .push             (push)
   );

   gasp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_result_kind = rsp_item.result_kind;
   assign rsp_start_u     = rsp_item.start_u;
   assign rsp_start_v     = rsp_item.start_v;
   assign rsp_size_u      = rsp_item.size_u;
   assign rsp_size_v      = rsp_item.size_v;
   assign rsp_page_index  = rsp_item.page_index;
   assign rsp_used_height = rsp_item.used_height;
   assign rsp_last        = rsp_item.last;

`ifndef SYNTHESIS
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> room)
      else $error("result pushed without queue room");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0)
      else $error("second result without first");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> (push.item0.result_kind == RK_CLOSE) && !push.item0.last &&
                     (push.item1.result_kind == RK_PLACE) && push.item1.last)
      else $error("page close and placement out of order");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== sv/gasp_csr.sv =====
`default_nettype none

module gasp_csr
   import gasp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_type idx;
   logic    wr;

   assign idx        = reg_type'(csr_paddr[4:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_PAGE_WIDTH:  cfg_in.page_width  = csr_pwdata[12:0];
            REG_PAGE_HEIGHT: cfg_in.page_height = csr_pwdata[12:0];
            REG_PAD_X:       cfg_in.pad_x       = csr_pwdata[7:0];
            REG_PAD_Y:       cfg_in.pad_y       = csr_pwdata[7:0];
            REG_GROW_LEFT:   cfg_in.grow_left   = $signed(csr_pwdata[8:0]);
            REG_GROW_RIGHT:  cfg_in.grow_right  = $signed(csr_pwdata[8:0]);
            REG_GROW_TOP:    cfg_in.grow_top    = $signed(csr_pwdata[8:0]);
            REG_GROW_BOTTOM: cfg_in.grow_bottom = $signed(csr_pwdata[8:0]);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_PAGE_WIDTH:  csr_prdata = {19'd0, cfg_ff.page_width};
         REG_PAGE_HEIGHT: csr_prdata = {19'd0, cfg_ff.page_height};
         REG_PAD_X:       csr_prdata = {24'd0, cfg_ff.pad_x};
         REG_PAD_Y:       csr_prdata = {24'd0, cfg_ff.pad_y};
         REG_GROW_LEFT:   csr_prdata = {23'd0, $unsigned(cfg_ff.grow_left)};
         REG_GROW_RIGHT:  csr_prdata = {23'd0, $unsigned(cfg_ff.grow_right)};
         REG_GROW_TOP:    csr_prdata = {23'd0, $unsigned(cfg_ff.grow_top)};
         REG_GROW_BOTTOM: csr_prdata = {23'd0, $unsigned(cfg_ff.grow_bottom)};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_width  <= 13'd256;
         cfg_ff.page_height <= 13'd256;
         cfg_ff.pad_x       <= 8'd1;
         cfg_ff.pad_y       <= 8'd1;
         cfg_ff.grow_left   <= 9'sd0;
         cfg_ff.grow_right  <= 9'sd0;
         cfg_ff.grow_top    <= 9'sd0;
         cfg_ff.grow_bottom <= 9'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/gasp_rsp_fifo.sv =====
`default_nettype none

module gasp_rsp_fifo
   import gasp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_item
);

   localparam int unsigned PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned CNT_W = PTR_W + 1;

   rsp_type            mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_nxt;
   logic               pop;

   assign room       = count_ff <= CNT_W'(RSP_DEPTH - 2);
   assign rsp_valid  = count_ff != '0;
   assign pop        = rsp_valid && rsp_ready;
   assign rsp_item   = mem_ff[rd_ptr_ff];
   assign wr_ptr_nxt = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.push0) + PTR_W'(push.push1);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_nxt] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/gasp_core.sv =====
`default_nettype none

module gasp_core
   import gasp_pkg::*;
#(
   parameter int unsigned P_SHADOW_MARGIN = SHADOW_MARGIN,
   parameter int unsigned P_MAX_PAGES     = MAX_PAGES
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [11:0] req_glyph_width,
   input  wire logic [11:0] req_glyph_height,
   input  wire logic        req_from_outline,
   input  wire cfg_type     cfg,
   input  wire logic        room,
   output push_type         push
);

   localparam logic [9:0] PAGE_LAST = 10'(P_MAX_PAGES - 1);

   function automatic logic [12:0] clamp_hi(input logic signed [15:0] v,
                                            input logic [12:0] hi);
      logic [12:0] r;
      if (v < 16'sd0) begin
         r = 13'd0;
      end else if (v > $signed({3'd0, hi})) begin
         r = hi;
      end else begin
         r = v[12:0];
      end
      return r;
   endfunction

   function automatic logic [9:0] inc_page(input logic [9:0] p);
      return (p < PAGE_LAST) ? p + 10'd1 : p;
   endfunction

   // input register
   logic        in_valid_ff, in_valid_in;
   kind_type    kind_ff;
   logic [11:0] gw_ff;
   logic [11:0] gh_ff;
   logic        outl_ff;

   // packing state
   logic [13:0] cursor_x_ff, cursor_x_in;
   logic [13:0] cursor_y_ff, cursor_y_in;
   logic [12:0] row_height_ff, row_height_in;
   logic [9:0]  page_ff, page_in;

   logic               fire;
   logic [12:0]        pw, ph;
   logic               too_big;
   logic [12:0]        w_eff, h_eff;
   logic               wrap, ovf;
   logic [15:0]        row_sum;
   logic [13:0]        cx1, cy1, cx2, cy2;
   logic [12:0]        rh1, rh2, rh3;
   logic [9:0]         pg2;
   logic [14:0]        fin_sum, ovf_sum;
   logic [13:0]        used_fin, used_ovf;
   logic signed [15:0] su_raw, sv_raw, zu_raw, zv_raw;
   logic [12:0]        su, sv, zu, zv;
   logic [15:0]        cx_sum;
   logic [13:0]        cx_fin;
   rsp_type            close_item, place_item, error_item;

   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
   end

   always_comb begin
      pw      = eff_dim(cfg.page_width);
      ph      = eff_dim(cfg.page_height);
      too_big = outl_ff && (({1'b0, gw_ff} > pw) || ({1'b0, gh_ff} > ph));
      w_eff   = {1'b0, gw_ff} + 13'(outl_ff) + 13'(P_SHADOW_MARGIN);
      h_eff   = {1'b0, gh_ff} + 13'(P_SHADOW_MARGIN);

      // wrap to a new row
      wrap    = ({2'd0, w_eff} + {1'b0, cursor_x_ff} + 15'(FIT_SLACK)) > {2'd0, pw};
      row_sum = {2'd0, cursor_y_ff} + {3'd0, row_height_ff} + {8'd0, cfg.pad_y};
      cx1     = wrap ? 14'd0 : cursor_x_ff;
      cy1     = wrap ? ((row_sum > 16'(CURSOR_MAX)) ? 14'(CURSOR_MAX) : row_sum[13:0])
                     : cursor_y_ff;
      rh1     = wrap ? 13'd0 : row_height_ff;
      rh2     = (h_eff > rh1) ? h_eff : rh1;

      // page overflow
      ovf      = ({1'b0, cy1} + {2'd0, rh2}) > {2'd0, ph};
      ovf_sum  = {1'b0, cy1} + {2'd0, rh1};
      used_ovf = (ovf_sum > 15'(USED_MAX)) ? 14'(USED_MAX) : ovf_sum[13:0];
      cx2      = ovf ? 14'd0 : cx1;
      cy2      = ovf ? 14'd0 : cy1;
      rh3      = ovf ? h_eff : rh2;
      pg2      = ovf ? inc_page(page_ff) : page_ff;

      fin_sum  = {1'b0, cursor_y_ff} + {2'd0, row_height_ff};
      used_fin = (fin_sum > 15'(USED_MAX)) ? 14'(USED_MAX) : fin_sum[13:0];

      // box clamp
      su_raw = $signed({2'd0, cx2}) - 16'(cfg.grow_left);
      sv_raw = $signed({2'd0, cy2}) + $signed(16'(!outl_ff)) - 16'(cfg.grow_top);
      su     = clamp_hi(su_raw, pw - 13'd1);
      sv     = clamp_hi(sv_raw, ph - 13'd1);
      zu_raw = $signed({3'd0, w_eff}) + 16'(cfg.grow_left) + 16'(cfg.grow_right);
      zv_raw = $signed({3'd0, h_eff}) + 16'(cfg.grow_top) + 16'(cfg.grow_bottom);
      zu     = clamp_hi(zu_raw, pw - su);
      zv     = clamp_hi(zv_raw, ph - sv);

      cx_sum = {2'd0, cx2} + {3'd0, w_eff} + {8'd0, cfg.pad_x};
      cx_fin = (cx_sum > 16'(CURSOR_MAX)) ? 14'(CURSOR_MAX) : cx_sum[13:0];
   end

   always_comb begin
      close_item             = '0;
      close_item.result_kind = RK_CLOSE;
      close_item.page_index  = page_ff;
      close_item.used_height = (kind_ff == KIND_FINISH) ? used_fin : used_ovf;
      close_item.last        = (kind_ff == KIND_FINISH);

      error_item             = '0;
      error_item.result_kind = RK_ERROR;
      error_item.page_index  = page_ff;
      error_item.last        = 1'b1;

      place_item             = '0;
      place_item.result_kind = RK_PLACE;
      place_item.start_u     = su[11:0];
      place_item.start_v     = sv[11:0];
      place_item.size_u      = zu;
      place_item.size_v      = zv;
      place_item.page_index  = pg2;
      place_item.last        = 1'b1;
   end

   always_comb begin
      push          = '0;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      row_height_in = row_height_ff;
      page_in       = page_ff;
      if (fire) begin
         priority if (kind_ff == KIND_FINISH) begin
            push.push0    = 1'b1;
            push.item0    = close_item;
            cursor_x_in   = 14'd0;
            cursor_y_in   = 14'd0;
            row_height_in = 13'd0;
            page_in       = inc_page(page_ff);
         end else if (too_big) begin
            push.push0 = 1'b1;
            push.item0 = error_item;
         end else begin
            push.push0    = 1'b1;
            push.push1    = ovf;
            push.item0    = ovf ? close_item : place_item;
            push.item1    = place_item;
            cursor_x_in   = cx_fin;
            cursor_y_in   = cy2;
            row_height_in = rh3;
            page_in       = pg2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= kind_type'(req_kind);
         gw_ff   <= req_glyph_width;
         gh_ff   <= req_glyph_height;
         outl_ff <= req_from_outline;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         row_height_ff <= '0;
         page_ff       <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         row_height_ff <= row_height_in;
         page_ff       <= page_in;
      end
   end

endmodule

`default_nettype wire
